// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the mesh node token parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MNTP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define MNTP_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define MNTP_ASSERT(lbl, clk, rstn, prop)
`define MNTP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- rtl/mntp_pkg.sv -----
package mntp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned OUT_DEPTH       = 4;
  localparam int unsigned TYPE_W          = 4;

  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_IDENT  = 4'd1;
  localparam logic [3:0] K_INT    = 4'd2;
  localparam logic [3:0] K_FLOAT  = 4'd3;
  localparam logic [3:0] K_STRING = 4'd4;
  localparam logic [3:0] K_COLON  = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_OPEN   = 4'd7;
  localparam logic [3:0] K_CLOSE  = 4'd8;
  localparam logic [3:0] K_LETTER = 4'd9;

  localparam logic [2:0] N_OBJECTS   = 3'd1;
  localparam logic [2:0] N_MODEL     = 3'd2;
  localparam logic [2:0] N_VERTICES  = 3'd3;
  localparam logic [2:0] N_INDICES   = 3'd4;
  localparam logic [2:0] N_LAYERNORM = 3'd5;
  localparam logic [2:0] N_NORMALS   = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BRACES    = 3'd1;
  localparam logic [2:0] ST_NAME_EXP  = 3'd2;
  localparam logic [2:0] ST_COLON_EXP = 3'd3;
  localparam logic [2:0] ST_PROP_EXP  = 3'd4;
  localparam logic [2:0] ST_TOO_DEEP  = 3'd5;
  localparam logic [2:0] ST_AFTER_END = 3'd6;

  localparam logic [1:0] D_NONE   = 2'd0;
  localparam logic [1:0] D_VERTEX = 2'd1;
  localparam logic [1:0] D_INDEX  = 2'd2;
  localparam logic [1:0] D_NORMAL = 2'd3;

  typedef enum logic [3:0] {
    T_NONE,
    T_UNKNOWN,
    T_OBJECTS,
    T_MODEL,
    T_MESH,
    T_VERTICES,
    T_INDICES,
    T_LAYERNORM,
    T_NORMALS
  } node_type_e;

  typedef enum logic [2:0] {
    PS_NAME,
    PS_COLON,
    PS_AFTER_COLON,
    PS_PROP,
    PS_AFTER_PROP,
    PS_ENDED
  } parse_state_e;

  typedef struct packed {
    logic [2:0] status;
    logic       finished;
    logic       colon;
    logic       comma;
    logic       push;
    logic       pop;
    logic       start;
    logic       prop;
    logic       to_end;
  } action_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        finished;
    logic [1:0]  dest;
    logic [31:0] value;
    logic        mesh_done;
    logic [15:0] mesh_name;
    logic [31:0] vcount;
    logic [31:0] icount;
    logic [31:0] ncount;
  } out_item_t;

endpackage

// ----- rtl/mesh_node_token_parser.sv -----
// Mesh node token parser.
// Input channel (in_valid_i / in_ready_o): one classified token per item.
// Output channel (out_valid_o / out_ready_i): exactly one result item per
// token, in order: grammar status, end flag, a routed vertex, index or
// normal value, and the summary of a mesh model that ended on this token.
// Throughput: one item per clock while in_ready_o is high. The node type
// stack sits in a two-port RAM (one write, one read port) with registered
// read; the entry under the top is prefetched each cycle from the next
// stack level, with a bypass when a push writes the same entry, so a close
// or open followed at once by a name is served.
// An accepted item is parsed and routed into s1, takes magnitude and
// leading-zero count into s2, then is shifted and rounded into the queue.
// Results wait in a four-entry output queue; in_ready_o drops while the
// queue plus the two conversion stages hold four items, so a stalled
// receiver never loses a result and full rate resumes as soon as it takes.
// Reset: grammar expects a node name, stack holds one level of unknown
// type, counts and name are zero, pipeline and queue are empty. The stack
// RAM needs no clearing pass.
`include "assert_macros.svh"
module mesh_node_token_parser import mntp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         token_kind_i,
  input  logic [2:0]         name_code_i,
  input  logic               string_is_mesh_i,
  input  logic [15:0]        string_handle_i,
  input  logic signed [31:0] int_value_i,
  input  logic [31:0]        float_bits_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               finished_o,
  output logic [1:0]         value_dest_o,
  output logic [31:0]        routed_value_o,
  output logic               mesh_done_o,
  output logic [15:0]        mesh_name_handle_o,
  output logic [31:0]        vertex_count_o,
  output logic [31:0]        index_count_o,
  output logic [31:0]        normal_count_o
);

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  logic         in_acc;
  logic         is_prop;
  logic         open_req;
  logic         name_path;
  action_t      act;

  parse_state_e state_q, state_d;
  node_type_e   top_q, top_d;
  node_type_e   parent;
  node_type_e   new_type;
  logic [LVL_W-1:0] level_q, level_d;
  logic [1:0]   pos_q, pos_d;
  logic [15:0]  name_ref_q, name_ref_d;
  logic [31:0]  vcnt_q, vcnt_d;
  logic [31:0]  icnt_q, icnt_d;
  logic [31:0]  ncnt_q, ncnt_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [TYPE_W-1:0] ram_wdata;
  logic [TYPE_W-1:0] ram_rdata;
  logic              fwd_q;
  logic [TYPE_W-1:0] fwd_data_q;

  logic [31:0]  fval;
  logic         fconv;
  out_item_t    res_d;
  logic         conv_d;

  logic         s1_valid_q;
  out_item_t    s1_item_q;
  logic         s1_conv_q;
  logic [31:0]  mag1;
  logic [4:0]   lzc1;

  logic         s2_valid_q;
  out_item_t    s2_item_q;
  logic         s2_conv_q;
  logic         s2_sign_q;
  logic [31:0]  s2_mag_q;
  logic [4:0]   s2_lzc_q;
  logic         s2_zero_q;
  logic [31:0]  norm;
  logic         rnd;
  logic [24:0]  m25;
  logic [7:0]   expo;
  out_item_t    item2;

  out_item_t        fifo_q [OUT_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W:0]   occ;
  logic             pop_out;
  out_item_t        head;

  assign occ = {1'b0, cnt_q} + (CNT_W + 1)'(s1_valid_q) + (CNT_W + 1)'(s2_valid_q);
  assign in_ready_o = occ < (CNT_W + 1)'(OUT_DEPTH);
  assign in_acc = in_valid_i && in_ready_o;
  assign is_prop = token_kind_i inside {K_INT, K_FLOAT, K_STRING, K_LETTER};
  assign parent = fwd_q ? node_type_e'(fwd_data_q) : node_type_e'(ram_rdata);

  // Token decode.
  always_comb begin
    act = '0;
    open_req = 1'b0;
    name_path = 1'b0;
    if (in_acc) begin
      case (state_q)
        PS_NAME: begin
          name_path = 1'b1;
        end
        PS_COLON: begin
          if (token_kind_i == K_COLON) act.colon = 1'b1;
          else act.status = ST_COLON_EXP;
        end
        PS_AFTER_COLON: begin
          if (token_kind_i == K_OPEN) open_req = 1'b1;
          else if (is_prop) act.prop = 1'b1;
          else name_path = 1'b1;
        end
        PS_PROP: begin
          if (is_prop) act.prop = 1'b1;
          else act.status = ST_PROP_EXP;
        end
        PS_AFTER_PROP: begin
          if (token_kind_i == K_COMMA) act.comma = 1'b1;
          else if (token_kind_i == K_OPEN) open_req = 1'b1;
          else name_path = 1'b1;
        end
        default: begin
          act.status = ST_AFTER_END;
        end
      endcase
      if (open_req) begin
        if (level_q >= LVL_W'(STACK_DEPTH)) act.status = ST_TOO_DEEP;
        else act.push = 1'b1;
      end
      if (name_path) begin
        if (token_kind_i == K_CLOSE) begin
          if (level_q == LVL_W'(1)) act.status = ST_BRACES;
          else act.pop = 1'b1;
        end else if (token_kind_i == K_END) begin
          act.to_end = 1'b1;
          if (level_q != LVL_W'(1)) act.status = ST_BRACES;
          else act.finished = 1'b1;
        end else if (token_kind_i == K_IDENT) begin
          act.start = 1'b1;
        end else begin
          act.status = ST_NAME_EXP;
        end
      end
    end
  end

  // Next parse state.
  always_comb begin
    state_d = state_q;
    if (act.colon) state_d = PS_AFTER_COLON;
    else if (act.comma) state_d = PS_PROP;
    else if (act.push || act.pop) state_d = PS_NAME;
    else if (act.start) state_d = PS_COLON;
    else if (act.prop) state_d = PS_AFTER_PROP;
    else if (act.to_end) state_d = PS_ENDED;
  end

  always_comb begin
    fval = 32'd0;
    fconv = 1'b0;
    if (token_kind_i == K_FLOAT) begin
      fval = float_bits_i;
    end else if (token_kind_i == K_INT) begin
      fval = int_value_i;
      fconv = 1'b1;
    end
  end

  // Stack, counts and routing.
  always_comb begin
    top_d = top_q;
    level_d = level_q;
    pos_d = pos_q;
    name_ref_d = name_ref_q;
    vcnt_d = vcnt_q;
    icnt_d = icnt_q;
    ncnt_d = ncnt_q;
    ram_we = 1'b0;
    ram_wdata = top_q;
    new_type = T_UNKNOWN;
    res_d = '0;
    res_d.status = act.status;
    res_d.finished = act.finished;
    conv_d = 1'b0;
    if (act.start) begin
      if (top_q == T_MESH) begin
        res_d.mesh_done = 1'b1;
        res_d.mesh_name = name_ref_q;
        res_d.vcount = vcnt_q;
        res_d.icount = icnt_q;
        res_d.ncount = ncnt_q;
        vcnt_d = '0;
        icnt_d = '0;
        ncnt_d = '0;
      end
      if (level_q == LVL_W'(1)) begin
        if (name_code_i == N_OBJECTS) new_type = T_OBJECTS;
      end else begin
        case (parent)
          T_OBJECTS: begin
            if (name_code_i == N_MODEL) new_type = T_MODEL;
          end
          T_MESH: begin
            if (name_code_i == N_VERTICES && vcnt_d == '0) new_type = T_VERTICES;
            else if (name_code_i == N_INDICES && icnt_d == '0) new_type = T_INDICES;
            else if (name_code_i == N_LAYERNORM) new_type = T_LAYERNORM;
          end
          T_LAYERNORM: begin
            if (name_code_i == N_NORMALS && ncnt_d == '0) new_type = T_NORMALS;
          end
          default: begin
          end
        endcase
      end
      top_d = new_type;
      pos_d = 2'd0;
    end
    if (act.pop) begin
      top_d = parent;
      level_d = level_q - LVL_W'(1);
    end
    if (act.push) begin
      ram_we = 1'b1;
      top_d = T_NONE;
      level_d = level_q + LVL_W'(1);
    end
    if (act.prop) begin
      case (top_q)
        T_MODEL: begin
          if (pos_q == 2'd0 && token_kind_i == K_STRING) name_ref_d = string_handle_i;
          if (pos_q == 2'd1 && token_kind_i == K_STRING && string_is_mesh_i) begin
            top_d = T_MESH;
            vcnt_d = '0;
            icnt_d = '0;
            ncnt_d = '0;
          end
        end
        T_VERTICES: begin
          res_d.dest = D_VERTEX;
          res_d.value = fval;
          conv_d = fconv;
          vcnt_d = (vcnt_q == '1) ? vcnt_q : vcnt_q + 32'd1;
        end
        T_INDICES: begin
          res_d.dest = D_INDEX;
          res_d.value = (token_kind_i == K_INT) ? int_value_i : 32'd0;
          icnt_d = (icnt_q == '1) ? icnt_q : icnt_q + 32'd1;
        end
        T_NORMALS: begin
          res_d.dest = D_NORMAL;
          res_d.value = fval;
          conv_d = fconv;
          ncnt_d = (ncnt_q == '1) ? ncnt_q : ncnt_q + 32'd1;
        end
        default: begin
        end
      endcase
      if (pos_q != 2'd3) pos_d = pos_q + 2'd1;
    end
  end

  assign ram_waddr = AW'(level_q - LVL_W'(1));
  assign ram_raddr = AW'(level_d - LVL_W'(2));

  mntp_ram #(
    .WIDTH(TYPE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_NAME;
      top_q <= T_UNKNOWN;
      level_q <= LVL_W'(1);
      pos_q <= 2'd0;
      name_ref_q <= 16'd0;
      vcnt_q <= 32'd0;
      icnt_q <= 32'd0;
      ncnt_q <= 32'd0;
      fwd_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q <= top_d;
      level_q <= level_d;
      pos_q <= pos_d;
      name_ref_q <= name_ref_d;
      vcnt_q <= vcnt_d;
      icnt_q <= icnt_d;
      ncnt_q <= ncnt_d;
      fwd_q <= ram_we && (ram_waddr == ram_raddr);
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Magnitude and leading-zero count.
  always_comb begin
    mag1 = s1_item_q.value[31] ? (32'd0 - s1_item_q.value) : s1_item_q.value;
    lzc1 = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag1[i]) lzc1 = 5'(31 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
    s1_item_q <= res_d;
    s1_conv_q <= conv_d;
    s2_item_q <= s1_item_q;
    s2_conv_q <= s1_conv_q;
    s2_sign_q <= s1_item_q.value[31];
    s2_mag_q <= mag1;
    s2_lzc_q <= lzc1;
    s2_zero_q <= (mag1 == 32'd0);
  end

  // Normalize and round to nearest even.
  always_comb begin
    norm = s2_mag_q << s2_lzc_q;
    rnd = norm[7] && ((|norm[6:0]) || norm[8]);
    m25 = {1'b0, norm[31:8]} + 25'(rnd);
    expo = 8'd158 - {3'b000, s2_lzc_q} + 8'(m25[24]);
    item2 = s2_item_q;
    if (s2_conv_q) begin
      if (s2_zero_q) item2.value = 32'd0;
      else item2.value = {s2_sign_q, expo, m25[24] ? 23'd0 : m25[22:0]};
    end
  end

  assign pop_out = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (s2_valid_q) wptr_q <= wptr_q + PTR_W'(1);
      if (pop_out) rptr_q <= rptr_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(s2_valid_q) - CNT_W'(pop_out);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      fifo_q[wptr_q] <= item2;
    end
  end

  assign head = fifo_q[rptr_q];
  assign out_valid_o = cnt_q != '0;
  assign status_o = head.status;
  assign finished_o = head.finished;
  assign value_dest_o = head.dest;
  assign routed_value_o = head.value;
  assign mesh_done_o = head.mesh_done;
  assign mesh_name_handle_o = head.mesh_name;
  assign vertex_count_o = head.vcount;
  assign index_count_o = head.icount;
  assign normal_count_o = head.ncount;

  `MNTP_ASSERT_NEVER(a_occ_bound, clk_i, rst_ni, occ > (CNT_W + 1)'(OUT_DEPTH))
  `MNTP_ASSERT(a_level_range, clk_i, rst_ni, (level_q != '0) && (level_q <= LVL_W'(STACK_DEPTH)))
  `MNTP_ASSERT(a_end_sticky, clk_i, rst_ni, (state_q == PS_ENDED) |=> (state_q == PS_ENDED))
  `MNTP_ASSERT(a_push_level, clk_i, rst_ni, act.push |=> (level_q == $past(level_q) + LVL_W'(1)))
  `MNTP_ASSERT(a_pipe_flow, clk_i, rst_ni, s1_valid_q |=> s2_valid_q)

endmodule

// ----- rtl/mntp_ram.sv -----
module mntp_ram import mntp_pkg::*; #(
  parameter int unsigned WIDTH = TYPE_W,
  parameter int unsigned DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/mesh_node_token_parser_tb.sv -----
`timescale 1ns / 1ps

module mesh_node_token_parser_tb import mntp_pkg::*;;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  name;
    logic        is_mesh;
    logic [15:0] handle;
    logic [31:0] ival;
    logic [31:0] fbits;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  token_kind_i;
  logic [2:0]  name_code_i;
  logic        string_is_mesh_i;
  logic [15:0] string_handle_i;
  logic [31:0] int_value_i;
  logic [31:0] float_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic        finished_o;
  logic [1:0]  value_dest_o;
  logic [31:0] routed_value_o;
  logic        mesh_done_o;
  logic [15:0] mesh_name_handle_o;
  logic [31:0] vertex_count_o;
  logic [31:0] index_count_o;
  logic [31:0] normal_count_o;

  parse_state_e pstate;
  node_type_e   type_stack [DEPTH];
  int unsigned  level;
  logic [1:0]   prop_pos;
  logic [15:0]  name_ref;
  logic [31:0]  vertices_seen;
  logic [31:0]  indices_seen;
  logic [31:0]  normals_seen;
  out_item_t    predicted;

  out_item_t pending_results[$];
  bit        no_idle = 1'b0;
  int        fail_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        meshes_reported = 0;
  int        values_routed = 0;

  mesh_node_token_parser #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .token_kind_i      (token_kind_i),
    .name_code_i       (name_code_i),
    .string_is_mesh_i  (string_is_mesh_i),
    .string_handle_i   (string_handle_i),
    .int_value_i       (int_value_i),
    .float_bits_i      (float_bits_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .finished_o        (finished_o),
    .value_dest_o      (value_dest_o),
    .routed_value_o    (routed_value_o),
    .mesh_done_o       (mesh_done_o),
    .mesh_name_handle_o(mesh_name_handle_o),
    .vertex_count_o    (vertex_count_o),
    .index_count_o     (index_count_o),
    .normal_count_o    (normal_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] int_to_binary32(logic [31:0] raw);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] m;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0]  e;
    int          p;
    int          sh;
    sgn = raw[31];
    mag = sgn ? -raw : raw;
    if (mag == 32'd0) return 32'd0;
    p = 31;
    while (!mag[p]) p--;
    e = 8'(127 + p);
    if (p <= 23) begin
      m = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      m = mag >> sh;
      if (rem > half || (rem == half && m[0])) m++;
      if (m == 32'h0100_0000) begin
        m = m >> 1;
        e++;
      end
    end
    return {sgn, e, m[22:0]};
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic bit is_property(logic [3:0] k);
    return k == K_INT || k == K_FLOAT || k == K_STRING || k == K_LETTER;
  endfunction

  function automatic logic [2:0] open_level();
    if (level >= DEPTH) return ST_TOO_DEEP;
    type_stack[level] = T_NONE;
    level++;
    pstate = PS_NAME;
    return ST_OK;
  endfunction

  function automatic logic [2:0] name_expected(token_t t);
    int unsigned top;
    node_type_e  kind_of;
    top = level - 1;
    if (t.kind == K_CLOSE) begin
      if (level == 1) return ST_BRACES;
      level--;
      pstate = PS_NAME;
      return ST_OK;
    end
    if (t.kind == K_END) begin
      pstate = PS_ENDED;
      if (level != 1) return ST_BRACES;
      predicted.finished = 1'b1;
      return ST_OK;
    end
    if (t.kind != K_IDENT) return ST_NAME_EXP;
    if (type_stack[top] == T_MESH) begin
      predicted.mesh_done = 1'b1;
      predicted.mesh_name = name_ref;
      predicted.vcount = vertices_seen;
      predicted.icount = indices_seen;
      predicted.ncount = normals_seen;
      vertices_seen = '0;
      indices_seen = '0;
      normals_seen = '0;
    end
    kind_of = T_UNKNOWN;
    if (level == 1) begin
      if (t.name == N_OBJECTS) kind_of = T_OBJECTS;
    end else begin
      case (type_stack[top - 1])
        T_OBJECTS: begin
          if (t.name == N_MODEL) kind_of = T_MODEL;
        end
        T_MESH: begin
          if (t.name == N_VERTICES && vertices_seen == 0) kind_of = T_VERTICES;
          else if (t.name == N_INDICES && indices_seen == 0) kind_of = T_INDICES;
          else if (t.name == N_LAYERNORM) kind_of = T_LAYERNORM;
        end
        T_LAYERNORM: begin
          if (t.name == N_NORMALS && normals_seen == 0) kind_of = T_NORMALS;
        end
        default: ;
      endcase
    end
    type_stack[top] = kind_of;
    prop_pos = 2'd0;
    pstate = PS_COLON;
    return ST_OK;
  endfunction

  function automatic void take_property(token_t t);
    int unsigned top;
    logic [31:0] fval;
    top = level - 1;
    fval = '0;
    if (t.kind == K_FLOAT) fval = t.fbits;
    else if (t.kind == K_INT) fval = int_to_binary32(t.ival);
    case (type_stack[top])
      T_MODEL: begin
        if (prop_pos == 2'd0 && t.kind == K_STRING) name_ref = t.handle;
        if (prop_pos == 2'd1 && t.kind == K_STRING && t.is_mesh) begin
          type_stack[top] = T_MESH;
          vertices_seen = '0;
          indices_seen = '0;
          normals_seen = '0;
        end
      end
      T_VERTICES: begin
        predicted.dest = D_VERTEX;
        predicted.value = fval;
        vertices_seen = sat_inc(vertices_seen);
      end
      T_INDICES: begin
        predicted.dest = D_INDEX;
        predicted.value = (t.kind == K_INT) ? t.ival : 32'd0;
        indices_seen = sat_inc(indices_seen);
      end
      T_NORMALS: begin
        predicted.dest = D_NORMAL;
        predicted.value = fval;
        normals_seen = sat_inc(normals_seen);
      end
      default: ;
    endcase
    if (prop_pos != 2'd3) prop_pos++;
  endfunction

  function automatic void advance_parser(token_t t);
    logic [2:0] st;
    predicted = '0;
    st = ST_OK;
    case (pstate)
      PS_NAME: st = name_expected(t);
      PS_COLON: begin
        if (t.kind != K_COLON) st = ST_COLON_EXP;
        else pstate = PS_AFTER_COLON;
      end
      PS_AFTER_COLON: begin
        if (t.kind == K_OPEN) begin
          st = open_level();
        end else if (is_property(t.kind)) begin
          take_property(t);
          pstate = PS_AFTER_PROP;
        end else begin
          st = name_expected(t);
        end
      end
      PS_PROP: begin
        if (!is_property(t.kind)) begin
          st = ST_PROP_EXP;
        end else begin
          take_property(t);
          pstate = PS_AFTER_PROP;
        end
      end
      PS_AFTER_PROP: begin
        if (t.kind == K_COMMA) pstate = PS_PROP;
        else if (t.kind == K_OPEN) st = open_level();
        else st = name_expected(t);
      end
      default: st = ST_AFTER_END;
    endcase
    predicted.status = st;
  endfunction

  function automatic token_t random_token();
    token_t t;
    t.kind = 4'($urandom_range(1, 15));
    t.name = 3'($urandom_range(0, 7));
    t.is_mesh = 1'($urandom_range(0, 1));
    t.handle = 16'($urandom_range(0, 65535));
    t.ival = $urandom;
    t.fbits = $urandom;
    return t;
  endfunction

  task automatic send_token(token_t t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    token_kind_i     <= t.kind;
    name_code_i      <= t.name;
    string_is_mesh_i <= t.is_mesh;
    string_handle_i  <= t.handle;
    int_value_i      <= t.ival;
    float_bits_i     <= t.fbits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_parser(t);
    pending_results.push_back(predicted);
    items_sent++;
  endtask

  task automatic put(logic [3:0] kind, logic [31:0] val = 32'd0);
    token_t t;
    t = random_token();
    t.kind = kind;
    case (kind)
      K_IDENT: t.name = val[2:0];
      K_INT: t.ival = val;
      K_FLOAT: t.fbits = val;
      K_STRING: begin
        t.handle = val[15:0];
        t.is_mesh = val[16];
      end
      default: ;
    endcase
    send_token(t);
  endtask

  task automatic put_property();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1: put(K_INT, v >> $urandom_range(0, 31));
      2: put(K_INT, ~(v >> $urandom_range(0, 31)));
      3: put(K_INT, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      4: put(K_INT, v);
      5, 6, 7: put(K_FLOAT, v);
      8: put(K_STRING, v);
      default: put(K_LETTER);
    endcase
  endtask

  task automatic put_values();
    int n;
    n = $urandom_range(1, 6);
    put_property();
    repeat (n - 1) begin
      put(K_COMMA);
      put_property();
    end
  endtask

  task automatic unwind_to_root();
    if (pstate == PS_COLON) put(K_COLON);
    else if (pstate == PS_PROP) put(K_LETTER);
    while (level > 1) put(K_CLOSE);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_grammar_errors();
    put(K_CLOSE);
    put(K_INT, 32'd5);
    put(4'd15);
    put(K_IDENT, 32'd7);
    put(K_COMMA);
    put(K_COLON);
    put(K_COMMA);
    put(K_LETTER);
    put(K_COMMA);
    put(K_COLON);
    put(K_FLOAT, 32'hFFFF_FFFF);
    put(K_OPEN);
    put(K_CLOSE);
  endtask

  task automatic test_mesh_routing();
    unwind_to_root();
    put(K_IDENT, 32'(N_OBJECTS));
    put(K_COLON);
    put(K_OPEN);
    put(K_IDENT, 32'(N_MODEL));
    put(K_COLON);
    put(K_STRING, 32'h0000_FFFF);
    put(K_COMMA);
    put(K_STRING, 32'h0001_0000);
    put(K_OPEN);
    put(K_IDENT, 32'(N_VERTICES));
    put(K_COLON);
    put(K_INT, 32'h8000_0000);
    put(K_COMMA);
    put(K_INT, 32'h7FFF_FFFF);
    put(K_COMMA);
    put(K_INT, 32'h0100_0003);
    put(K_IDENT, 32'(N_INDICES));
    put(K_COLON);
    put(K_FLOAT, 32'h3F80_0000);
    put(K_IDENT, 32'(N_LAYERNORM));
    put(K_COLON);
    put(K_OPEN);
    put(K_IDENT, 32'(N_NORMALS));
    put(K_COLON);
    put(K_LETTER);
    put(K_CLOSE);
    put(K_CLOSE);
    put(K_IDENT, 32'(N_MODEL));
  endtask

  task automatic test_deep_nesting();
    unwind_to_root();
    while (level < DEPTH) begin
      put(K_IDENT, $urandom_range(0, 7));
      put(K_COLON);
      put(K_OPEN);
    end
    put(K_IDENT, $urandom_range(0, 7));
    put(K_COLON);
    put(K_OPEN);
    put(K_INT, $urandom);
    put(K_OPEN);
    unwind_to_root();
  endtask

  task automatic test_random_meshes(int target);
    int         stop_at;
    int         files;
    logic [2:0] child;
    stop_at = items_sent + target;
    files = 0;
    while (items_sent < stop_at) begin
      no_idle = ($urandom_range(0, 3) == 0);
      put(K_IDENT, 32'(N_OBJECTS));
      put(K_COLON);
      put(K_OPEN);
      repeat ($urandom_range(1, 3)) begin
        put(K_IDENT, 32'(N_MODEL));
        put(K_COLON);
        if ($urandom_range(0, 4) != 0) put(K_STRING, $urandom_range(0, 65535));
        else put_property();
        put(K_COMMA);
        put(K_STRING, {15'd0, ($urandom_range(0, 3) != 0), 16'($urandom)});
        if ($urandom_range(0, 3) == 0) begin
          put(K_COMMA);
          put_property();
        end
        if ($urandom_range(0, 5) != 0) begin
          put(K_OPEN);
          repeat ($urandom_range(0, 4)) begin
            child = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(N_VERTICES, N_LAYERNORM));
            put(K_IDENT, 32'(child));
            put(K_COLON);
            if (child == N_LAYERNORM) begin
              put(K_INT, 32'd0);
              put(K_OPEN);
              put(K_IDENT, ($urandom_range(0, 4) != 0) ? 32'(N_NORMALS) : $urandom_range(0, 7));
              put(K_COLON);
              put_values();
              put(K_CLOSE);
            end else begin
              put_values();
            end
          end
          put(K_CLOSE);
        end
        if ($urandom_range(0, 9) == 0) send_token(random_token());
      end
      put(K_CLOSE);
      unwind_to_root();
      if (files == 0 || $urandom_range(0, 4) == 0) wait_for_results();
      files++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_noise(int count);
    repeat (count) send_token(random_token());
  endtask

  task automatic test_after_end();
    token_t t;
    unwind_to_root();
    put(K_END);
    put(K_END);
    repeat (4) begin
      t = random_token();
      t.kind = 4'($urandom_range(0, 15));
      send_token(t);
    end
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("finished", 32'(want.finished), 32'(finished_o));
        check_field("value_dest", 32'(want.dest), 32'(value_dest_o));
        check_field("routed_value", want.value, routed_value_o);
        check_field("mesh_done", 32'(want.mesh_done), 32'(mesh_done_o));
        check_field("mesh_name_handle", 32'(want.mesh_name), 32'(mesh_name_handle_o));
        check_field("vertex_count", want.vcount, vertex_count_o);
        check_field("index_count", want.icount, index_count_o);
        check_field("normal_count", want.ncount, normal_count_o);
        results_checked++;
        if (want.mesh_done) meshes_reported++;
        if (want.dest != D_NONE) values_routed++;
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    token_kind_i     = '0;
    name_code_i      = '0;
    string_is_mesh_i = 1'b0;
    string_handle_i  = '0;
    int_value_i      = '0;
    float_bits_i     = '0;
    pstate           = PS_NAME;
    foreach (type_stack[i]) type_stack[i] = T_NONE;
    type_stack[0]    = T_UNKNOWN;
    level            = 1;
    prop_pos         = 2'd0;
    name_ref         = '0;
    vertices_seen    = '0;
    indices_seen     = '0;
    normals_seen     = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_grammar_errors();
    test_mesh_routing();
    test_deep_nesting();
    test_random_meshes(260);
    test_noise(60);
    test_after_end();

    wait_for_results();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d tokens and %0d checked results.", items_sent, results_checked);
    $display("Mesh models reported: %0d, routed values: %0d.", meshes_reported, values_routed);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mntp_pkg.sv
rtl/mntp_ram.sv
rtl/mesh_node_token_parser.sv
bench/mesh_node_token_parser_tb.sv
